FILE: hw/rtl/prst_pkg.sv
// Package for the persistent range sum/min/max tree.
// Holds default sizes, field widths, command and status codes and result limits.
// No dependencies.
package prst_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int MAX_VERSIONS = 256;
	localparam int POOL_DEPTH   = 8192;

	localparam int CMD_W = 3;
	localparam int VER_W = 8;
	localparam int POS_W = 10;
	localparam int VAL_W = 32;
	localparam int ST_W  = 3;
	localparam int RES_W = 42;
	localparam int VH_W  = 9;
	localparam int SUM_W = 42;
	localparam int ACC_W = 48;

	localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SUM    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MIN    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_MAX    = 3'd4;

	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_BAD_VER = 3'd1;
	localparam logic [ST_W-1:0] ST_BAD_IDX = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
	localparam logic [ST_W-1:0] ST_EMPTY   = 3'd4;

	localparam logic signed [ACC_W-1:0] RES_TOP    = 48'sh01FF_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] RES_BOTTOM = 48'shFE00_0000_0000;

endpackage

FILE: hw/rtl/prst_if.sv
// Stream interfaces for the persistent range tree: command beats in, result beats out.
// Depends on prst_pkg for field widths.
interface prst_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [prst_pkg::CMD_W-1:0]          command;
	logic [prst_pkg::VER_W-1:0]          version_sel;
	logic [prst_pkg::POS_W-1:0]          position;
	logic [prst_pkg::POS_W-1:0]          right_bound;
	logic signed [prst_pkg::VAL_W-1:0]   element_value;
	logic                                last_element;

	modport source (output valid, command, version_sel, position, right_bound,
		element_value, last_element, input ready);
	modport sink (input valid, command, version_sel, position, right_bound,
		element_value, last_element, output ready);
endinterface

interface prst_res_if;
	logic                                valid;
	logic                                ready;
	logic [prst_pkg::ST_W-1:0]           status;
	logic [prst_pkg::VER_W-1:0]          version_out;
	logic signed [prst_pkg::RES_W-1:0]   query_result;
	logic [prst_pkg::VH_W-1:0]           versions_held;

	modport source (output valid, status, version_out, query_result, versions_held,
		input ready);
	modport sink (input valid, status, version_out, query_result, versions_held,
		output ready);
endinterface

FILE: hw/rtl/persistent_range_sum_min_max_tree.sv
// Persistent range sum/min/max tree: versioned node pool, one item at a time.
// Load buffers elements; the last one builds version 0 as a tree of 2n-1 nodes;
// update copies each node on the path to the leaf; query walks the visited nodes.
// One item in flight: a new command is taken only in idle, after the last result is registered.
// Reset clears counters, stack pointer and handshake state; memories are not cleared.
// Depends on prst_pkg and prst_if.
module persistent_range_sum_min_max_tree #(
	parameter int MAX_ELEMENTS = prst_pkg::MAX_ELEMENTS,
	parameter int MAX_VERSIONS = prst_pkg::MAX_VERSIONS,
	parameter int POOL_DEPTH   = prst_pkg::POOL_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	prst_cmd_if.sink       in_ch,
	prst_res_if.source     out_ch
);

	localparam int EW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW    = $clog2(MAX_ELEMENTS + 1);
	localparam int NW    = $clog2(POOL_DEPTH);
	localparam int PW    = $clog2(POOL_DEPTH + 1);
	localparam int VIW   = (MAX_VERSIONS > 1) ? $clog2(MAX_VERSIONS) : 1;
	localparam int VCW   = $clog2(MAX_VERSIONS + 1);
	localparam int STK_D = 2 * EW + 4;
	localparam int SW    = $clog2(STK_D + 1);
	localparam int SIW   = $clog2(STK_D);

	localparam int SUM_W = prst_pkg::SUM_W;
	localparam int VAL_W = prst_pkg::VAL_W;
	localparam int ACC_W = prst_pkg::ACC_W;
	localparam int RES_W = prst_pkg::RES_W;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic signed [VAL_W-1:0] mn;
		logic signed [VAL_W-1:0] mx;
		logic [NW-1:0]           lc;
		logic [NW-1:0]           rc;
	} node_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_OUT,
		B_TOP, B_LEAF, B_RD1, B_RD2,
		Q_ROOT, Q_TOP, Q_NODE,
		U_ROOT, U_DESC, U_SIB, U_UP
	} state_t;

	function automatic logic [NW-1:0] slot(input logic [NW-1:0] i);
		return (i < POOL_DEPTH) ? i : '0;
	endfunction

	function automatic node_t merge(input node_t a, input node_t b);
		node_t m;
		m.sum = a.sum + b.sum;
		m.mn  = (a.mn < b.mn) ? a.mn : b.mn;
		m.mx  = (a.mx > b.mx) ? a.mx : b.mx;
		m.lc  = '0;
		m.rc  = '0;
		return m;
	endfunction

	state_t state_q;

	logic [prst_pkg::CMD_W-1:0] cmd_q;
	logic [prst_pkg::VER_W-1:0] ver_q;
	logic [prst_pkg::POS_W-1:0] pos_q;
	logic [prst_pkg::POS_W-1:0] rb_q;
	logic signed [VAL_W-1:0]    val_q;
	logic                       last_q;

	logic [CW-1:0]  lc_q;
	logic [CW-1:0]  ec_q;
	logic [VCW-1:0] vc_q;
	logic [PW-1:0]  pu_q;
	logic [PW-1:0]  need_q;

	logic [EW-1:0] stk_lo_q [STK_D];
	logic [EW-1:0] stk_hi_q [STK_D];
	logic [NW-1:0] stk_ix_q [STK_D];
	logic [1:0]    stk_ph_q [STK_D];
	logic [SW-1:0] sp_q;

	logic [EW-1:0] cur_lo_q;
	logic [EW-1:0] cur_hi_q;
	logic [NW-1:0] cur_ix_q;
	logic [NW-1:0] cur_r_q;
	logic [EW-1:0] ql_q;
	logic [EW-1:0] qr_q;
	node_t         agg_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [prst_pkg::ST_W-1:0]  st_q;
	logic [prst_pkg::VER_W-1:0] vout_q;

	logic                       out_valid_q;
	logic [prst_pkg::ST_W-1:0]  out_st_q;
	logic [prst_pkg::VER_W-1:0] out_vout_q;
	logic signed [RES_W-1:0]    out_res_q;
	logic [prst_pkg::VH_W-1:0]  out_vh_q;

	node_t                   node_mem [POOL_DEPTH];
	node_t                   node_rd_q;
	logic [NW-1:0]           vr_mem [MAX_VERSIONS];
	logic [NW-1:0]           vr_rd_q;
	logic signed [VAL_W-1:0] lb_mem [MAX_ELEMENTS];
	logic signed [VAL_W-1:0] lb_rd_q;

	logic [NW-1:0]           node_ra;
	logic                    node_we;
	logic [NW-1:0]           node_wa;
	node_t                   node_wd;
	logic [EW-1:0]           lb_ra;
	logic                    lb_we;
	logic [VIW-1:0]          vr_ra;
	logic                    vr_we;
	logic [VIW-1:0]          vr_wa;
	logic [NW-1:0]           vr_wd;

	logic [SIW-1:0] top_ix;
	logic [EW-1:0]  t_lo, t_hi, t_mid, cur_mid, last_ix;
	logic [NW-1:0]  t_ix, t_rix, new_ix, up_ix;
	logic [1:0]     t_ph;
	logic [EW:0]    l_size;
	logic [CW-1:0]  n_load;
	logic [CW:0]    two_n;
	logic           build_fail, ver_bad, go_left, is_leaf, upd_full, covered;
	logic           upd_done;
	logic [CW-1:0]  top_el;
	logic [EW-1:0]  ql_c, qr_c;
	node_t          leaf_upd, up_node;
	logic signed [ACC_W-1:0] ident;

	assign top_ix  = SIW'(sp_q - SW'(1));
	assign t_lo    = stk_lo_q[top_ix];
	assign t_hi    = stk_hi_q[top_ix];
	assign t_ix    = stk_ix_q[top_ix];
	assign t_ph    = stk_ph_q[top_ix];
	assign t_mid   = t_lo + ((t_hi - t_lo) >> 1);
	assign l_size  = (EW+1)'(t_mid) - (EW+1)'(t_lo) + (EW+1)'(1);
	assign t_rix   = t_ix + NW'({l_size, 1'b0});
	assign cur_mid = cur_lo_q + ((cur_hi_q - cur_lo_q) >> 1);
	assign top_el  = ec_q - CW'(1);
	assign last_ix = EW'(top_el);
	assign ql_c    = (pos_q < top_el) ? EW'(pos_q) : EW'(top_el);
	assign qr_c    = (rb_q < top_el) ? EW'(rb_q) : EW'(top_el);
	assign n_load  = (lc_q < MAX_ELEMENTS) ? lc_q + CW'(1) : lc_q;
	assign two_n   = {n_load, 1'b0};
	assign build_fail = (n_load == '0) || ((two_n - (CW+1)'(1)) > POOL_DEPTH);
	assign ver_bad = (ver_q >= vc_q) || (ec_q == '0);
	assign go_left = pos_q <= cur_mid;
	assign is_leaf = cur_lo_q == cur_hi_q;
	assign upd_full = (vc_q >= MAX_VERSIONS)
		|| (((PW+1)'(pu_q) + (PW+1)'(sp_q) + (PW+1)'(1)) > POOL_DEPTH);
	assign covered = (ql_q <= cur_lo_q) && (cur_hi_q <= qr_q);
	assign new_ix  = NW'(pu_q + PW'(sp_q));
	assign up_ix   = NW'(pu_q + PW'(sp_q - SW'(1)));
	assign upd_done = ((state_q == U_DESC) && is_leaf && !upd_full && (sp_q == '0))
		|| ((state_q == U_UP) && (sp_q == SW'(1)));

	always_comb begin
		leaf_upd.sum = SUM_W'(val_q);
		leaf_upd.mn  = val_q;
		leaf_upd.mx  = val_q;
		leaf_upd.lc  = node_rd_q.lc;
		leaf_upd.rc  = node_rd_q.rc;
		up_node      = merge(agg_q, node_rd_q);
		if (t_ph[0]) begin
			up_node.lc = NW'(pu_q + PW'(sp_q));
			up_node.rc = t_ix;
		end else begin
			up_node.lc = t_ix;
			up_node.rc = NW'(pu_q + PW'(sp_q));
		end
	end

	always_comb begin
		case (cmd_q)
			prst_pkg::CMD_MIN: ident = prst_pkg::RES_TOP;
			prst_pkg::CMD_MAX: ident = prst_pkg::RES_BOTTOM;
			default:           ident = '0;
		endcase
	end

	always_comb begin
		node_ra = '0;
		node_we = 1'b0;
		node_wa = cur_ix_q;
		node_wd = merge(agg_q, node_rd_q);
		node_wd.lc = cur_ix_q + NW'(1);
		node_wd.rc = cur_r_q;
		lb_ra   = t_lo;
		lb_we   = (state_q == S_DISP) && (cmd_q == prst_pkg::CMD_LOAD)
			&& (lc_q < MAX_ELEMENTS);
		vr_ra   = VIW'(ver_q);
		vr_we   = 1'b0;
		vr_wa   = VIW'(vc_q);
		vr_wd   = NW'(pu_q);
		unique case (state_q)
			B_TOP: begin
				node_ra = t_ix + NW'(1);
				if (sp_q == '0) begin
					vr_we = 1'b1;
					vr_wa = '0;
					vr_wd = '0;
				end
			end
			B_LEAF: begin
				node_we    = 1'b1;
				node_wd.sum = SUM_W'(lb_rd_q);
				node_wd.mn = lb_rd_q;
				node_wd.mx = lb_rd_q;
				node_wd.lc = '0;
				node_wd.rc = '0;
			end
			B_RD1: node_ra = cur_r_q;
			B_RD2: node_we = 1'b1;
			Q_TOP: node_ra = slot(t_ix);
			U_ROOT: node_ra = slot(vr_rd_q);
			U_DESC: begin
				node_ra = slot(go_left ? node_rd_q.lc : node_rd_q.rc);
				if (is_leaf && !upd_full) begin
					node_we = 1'b1;
					node_wa = new_ix;
					node_wd = leaf_upd;
				end
				vr_we = upd_done;
			end
			U_SIB: node_ra = slot(t_ix);
			U_UP: begin
				node_we = 1'b1;
				node_wa = up_ix;
				node_wd = up_node;
				vr_we   = upd_done;
			end
			default: node_ra = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		node_rd_q <= node_mem[node_ra];
		if (node_we) node_mem[node_wa] <= node_wd;
	end

	always_ff @(posedge clk) begin
		lb_rd_q <= lb_mem[lb_ra];
		if (lb_we) lb_mem[lc_q[EW-1:0]] <= val_q;
	end

	always_ff @(posedge clk) begin
		vr_rd_q <= vr_mem[vr_ra];
		if (vr_we) vr_mem[vr_wa] <= vr_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lc_q        <= '0;
			ec_q        <= '0;
			vc_q        <= '0;
			pu_q        <= '0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			if (upd_done) begin
				vc_q   <= vc_q + VCW'(1);
				pu_q   <= pu_q + ((state_q == U_UP) ? need_q : PW'(1));
				vout_q <= prst_pkg::VER_W'(vc_q);
				st_q   <= prst_pkg::ST_OK;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						cmd_q   <= in_ch.command;
						ver_q   <= in_ch.version_sel;
						pos_q   <= in_ch.position;
						rb_q    <= in_ch.right_bound;
						val_q   <= in_ch.element_value;
						last_q  <= in_ch.last_element;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					st_q   <= prst_pkg::ST_OK;
					vout_q <= '0;
					acc_q  <= ident;
					unique case (cmd_q)
						prst_pkg::CMD_LOAD: begin
							if (lc_q < MAX_ELEMENTS) lc_q <= lc_q + CW'(1);
							else st_q <= prst_pkg::ST_FULL;
							state_q <= S_OUT;
							if (last_q) begin
								lc_q <= '0;
								if (build_fail) begin
									st_q <= prst_pkg::ST_FULL;
								end else begin
									ec_q        <= n_load;
									pu_q        <= PW'(two_n - (CW+1)'(1));
									stk_lo_q[0] <= '0;
									stk_hi_q[0] <= EW'(n_load - CW'(1));
									stk_ix_q[0] <= '0;
									stk_ph_q[0] <= 2'd0;
									sp_q        <= SW'(1);
									state_q     <= B_TOP;
								end
							end
						end
						prst_pkg::CMD_UPDATE: begin
							state_q <= S_OUT;
							if (ver_bad) begin
								st_q   <= prst_pkg::ST_BAD_VER;
								vout_q <= (vc_q != '0) ? prst_pkg::VER_W'(vc_q - VCW'(1)) : '0;
							end else if (pos_q >= ec_q) begin
								st_q   <= prst_pkg::ST_BAD_IDX;
								vout_q <= ver_q;
							end else begin
								state_q <= U_ROOT;
							end
						end
						prst_pkg::CMD_SUM, prst_pkg::CMD_MIN, prst_pkg::CMD_MAX: begin
							ql_q    <= ql_c;
							qr_q    <= qr_c;
							state_q <= S_OUT;
							if (ver_bad) st_q <= prst_pkg::ST_BAD_VER;
							else if (ql_c > qr_c) st_q <= prst_pkg::ST_EMPTY;
							else state_q <= Q_ROOT;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				B_TOP: begin
					if (sp_q == '0) begin
						vc_q    <= VCW'(1);
						state_q <= S_OUT;
					end else if (t_lo == t_hi) begin
						cur_ix_q <= t_ix;
						sp_q     <= sp_q - SW'(1);
						state_q  <= B_LEAF;
					end else if (t_ph == 2'd0) begin
						stk_ph_q[top_ix]       <= 2'd1;
						stk_lo_q[SIW'(sp_q)]   <= t_lo;
						stk_hi_q[SIW'(sp_q)]   <= t_mid;
						stk_ix_q[SIW'(sp_q)]   <= t_ix + NW'(1);
						stk_ph_q[SIW'(sp_q)]   <= 2'd0;
						sp_q                   <= sp_q + SW'(1);
					end else if (t_ph == 2'd1) begin
						stk_ph_q[top_ix]       <= 2'd2;
						stk_lo_q[SIW'(sp_q)]   <= t_mid + EW'(1);
						stk_hi_q[SIW'(sp_q)]   <= t_hi;
						stk_ix_q[SIW'(sp_q)]   <= t_rix;
						stk_ph_q[SIW'(sp_q)]   <= 2'd0;
						sp_q                   <= sp_q + SW'(1);
					end else begin
						cur_ix_q <= t_ix;
						cur_r_q  <= t_rix;
						sp_q     <= sp_q - SW'(1);
						state_q  <= B_RD1;
					end
				end
				B_LEAF: state_q <= B_TOP;
				B_RD1: begin
					agg_q   <= node_rd_q;
					state_q <= B_RD2;
				end
				B_RD2: state_q <= B_TOP;
				Q_ROOT: begin
					stk_lo_q[0] <= '0;
					stk_hi_q[0] <= last_ix;
					stk_ix_q[0] <= vr_rd_q;
					sp_q        <= SW'(1);
					state_q     <= Q_TOP;
				end
				Q_TOP: begin
					if (sp_q == '0) begin
						state_q <= S_OUT;
					end else begin
						sp_q     <= sp_q - SW'(1);
						cur_lo_q <= t_lo;
						cur_hi_q <= t_hi;
						if (!((ql_q > t_hi) || (qr_q < t_lo))) state_q <= Q_NODE;
					end
				end
				Q_NODE: begin
					state_q <= Q_TOP;
					if (covered) begin
						case (cmd_q)
							prst_pkg::CMD_SUM:
								acc_q <= acc_q + ACC_W'($signed(node_rd_q.sum));
							prst_pkg::CMD_MIN:
								if (ACC_W'($signed(node_rd_q.mn)) < acc_q)
									acc_q <= ACC_W'($signed(node_rd_q.mn));
							default:
								if (ACC_W'($signed(node_rd_q.mx)) > acc_q)
									acc_q <= ACC_W'($signed(node_rd_q.mx));
						endcase
					end else begin
						stk_lo_q[SIW'(sp_q)]         <= cur_mid + EW'(1);
						stk_hi_q[SIW'(sp_q)]         <= cur_hi_q;
						stk_ix_q[SIW'(sp_q)]         <= node_rd_q.rc;
						stk_lo_q[SIW'(sp_q + SW'(1))] <= cur_lo_q;
						stk_hi_q[SIW'(sp_q + SW'(1))] <= cur_mid;
						stk_ix_q[SIW'(sp_q + SW'(1))] <= node_rd_q.lc;
						sp_q                         <= sp_q + SW'(2);
					end
				end
				U_ROOT: begin
					cur_lo_q <= '0;
					cur_hi_q <= last_ix;
					sp_q     <= '0;
					state_q  <= U_DESC;
				end
				U_DESC: begin
					if (is_leaf) begin
						if (upd_full) begin
							st_q    <= prst_pkg::ST_FULL;
							vout_q  <= prst_pkg::VER_W'(vc_q - VCW'(1));
							state_q <= S_OUT;
						end else begin
							agg_q   <= leaf_upd;
							need_q  <= PW'(sp_q) + PW'(1);
							state_q <= (sp_q == '0) ? S_OUT : U_SIB;
						end
					end else begin
						stk_ix_q[SIW'(sp_q)] <= go_left ? node_rd_q.rc : node_rd_q.lc;
						stk_ph_q[SIW'(sp_q)] <= {1'b0, go_left};
						sp_q                 <= sp_q + SW'(1);
						if (go_left) cur_hi_q <= cur_mid;
						else cur_lo_q <= cur_mid + EW'(1);
					end
				end
				U_SIB: state_q <= U_UP;
				U_UP: begin
					agg_q   <= up_node;
					sp_q    <= sp_q - SW'(1);
					state_q <= (sp_q == SW'(1)) ? S_OUT : U_SIB;
				end
				S_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_st_q    <= st_q;
						out_vout_q  <= vout_q;
						out_vh_q    <= prst_pkg::VH_W'(vc_q);
						if (acc_q > prst_pkg::RES_TOP) out_res_q <= RES_W'(prst_pkg::RES_TOP);
						else if (acc_q < prst_pkg::RES_BOTTOM)
							out_res_q <= RES_W'(prst_pkg::RES_BOTTOM);
						else out_res_q <= RES_W'(acc_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready          = (state_q == S_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = out_st_q;
	assign out_ch.version_out   = out_vout_q;
	assign out_ch.query_result  = out_res_q;
	assign out_ch.versions_held = out_vh_q;

	a_vc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vc_q <= MAX_VERSIONS) else $error("version count beyond table");
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pu_q <= POOL_DEPTH) else $error("node pool overrun");
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= STK_D) else $error("walk stack overrun");
	a_vc_needs_elems: assert property (@(posedge clk) disable iff (!arst_n)
		(vc_q != '0) |-> (ec_q != '0)) else $error("versions held with empty array");
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lc_q <= MAX_ELEMENTS) else $error("load count beyond buffer");

endmodule
